FILE: hw/rtl/complex_fir_pulse_shaper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex FIR pulse shaper
// Shorthand for the clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_PULSE_SHAPER_TOP_MACROS_SVH
`define COMPLEX_FIR_PULSE_SHAPER_TOP_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define CFPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfps: next-cycle check failed");

// antecedent implies consequent in the same cycle
`define CFPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfps: same-cycle check failed");

`endif

FILE: hw/rtl/cfps_pkg.sv
// ----------------------------------------------------------------------------
// cfps_pkg
// Shared widths, codes, state type and control structs of the pulse shaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfps_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 15;
   localparam int TAP_IDX_W     = 9;
   localparam int PROD_W        = 2 * SAMPLE_W;
   localparam int FRAC_SHIFT    = 30;
   localparam int TAP_COUNT_DEF = 301;

   localparam logic [GAIN_W-1:0]   GAIN_RESET = 15'd1500;
   localparam logic [SAMPLE_W-1:0] SAT_MAX    = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_MIN    = 16'h8000;

   // request opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_GAIN_LO,
      ST_GAIN_HI,
      ST_SUM,
      ST_OUT
   } cfps_state_type;

   typedef struct packed {
      logic clear_step;
      logic load_tap;
      logic start_sample;
      logic mac_issue;
      logic gain_lo;
      logic gain_hi;
      logic sum;
      logic out_load;
   } cfps_cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic pipe_busy;
      logic rsp_free;
   } cfps_status_type;

endpackage

FILE: hw/rtl/complex_fir_pulse_shaper_top.sv
// ----------------------------------------------------------------------------
// complex_fir_pulse_shaper_top
// Complex-sample FIR with real Q1.15 taps, integer gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/stall): op = OP_LOAD writes tap_value into tap
//    tap_index (indexes at or beyond TAP_COUNT are dropped); op = OP_SAMPLE
//    pushes one I/Q pair into the delay line and yields one rsp request.
//    Every tap must be loaded before the first sample request.
//  - rsp channel (valid/stall): out_i, out_q and clipped, held in an output
//    register while stalled; the next request is taken while it waits.
//  - csr channel (valid/ready): output_gain, ready always high; write only
//    while the block is idle. Resets to 1500.
//  - A tap load leaves the block ready for the next request. A sample runs
//    from acceptance to rsp_valid through the single complex MAC walking
//    the taps one per cycle through the memory read port, then pipeline
//    drain, two gain multiply steps, a sum and saturation.
//  - One sample is processed at a time: the next request is taken in the
//    cycle after the result is loaded.
//  - Flush with trailing zeros.
//  - Reset: a clearing pass zeroes both delay lines, one entry per cycle,
//    over all TAP_COUNT entries; req_stall stays high meanwhile. csr writes
//    are taken throughout. A stalled rsp holds the block in its final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_fir_pulse_shaper_top
   import cfps_pkg::*;
#(
   parameter int TAP_COUNT = TAP_COUNT_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [TAP_IDX_W-1:0]       req_tap_index,
   input  logic signed [SAMPLE_W-1:0] req_tap_value,
   input  logic signed [SAMPLE_W-1:0] req_sample_i,
   input  logic signed [SAMPLE_W-1:0] req_sample_q,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_out_i,
   output logic signed [SAMPLE_W-1:0] rsp_out_q,
   output logic                       rsp_clipped,
   // gain register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [GAIN_W-1:0]          csr_output_gain
);

   cfps_cmd_type    cmd;
   cfps_status_type status;

   assign csr_ready = 1'b1;

   cfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cfps_datapath #(
      .TAP_COUNT (TAP_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_tap_index   (req_tap_index),
      .req_tap_value   (req_tap_value),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_output_gain (csr_output_gain),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .rsp_clipped     (rsp_clipped)
   );

endmodule

FILE: hw/rtl/cfps_ctrl.sv
// ----------------------------------------------------------------------------
// cfps_ctrl
// Sequencer: clearing pass, tap walk, gain steps and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfps_ctrl
   import cfps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_op,
   output logic            req_stall,
   input  cfps_status_type status,
   output cfps_cmd_type    cmd
);

   cfps_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_op == OP_SAMPLE) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (status.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_GAIN_LO;
         end
         ST_GAIN_LO: state_in = ST_GAIN_HI;
         ST_GAIN_HI: state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd              = '0;
      req_stall        = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_stall        = 1'b0;
            cmd.load_tap     = req_valid && req_op == OP_LOAD;
            cmd.start_sample = req_valid && req_op == OP_SAMPLE;
         end
         ST_MAC:     cmd.mac_issue = 1'b1;
         ST_DRAIN:   cmd = '0;
         ST_GAIN_LO: cmd.gain_lo = 1'b1;
         ST_GAIN_HI: cmd.gain_hi = 1'b1;
         ST_SUM:     cmd.sum = 1'b1;
         ST_OUT:     cmd.out_load = status.rsp_free;
         default:    cmd = '0;
      endcase
   end

endmodule

FILE: hw/rtl/cfps_datapath.sv
// ----------------------------------------------------------------------------
// cfps_datapath
// Tap and delay memories, shared complex MAC, gain multiply, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfps_datapath
   import cfps_pkg::*;
#(
   parameter int TAP_COUNT = TAP_COUNT_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfps_cmd_type               cmd,
   output cfps_status_type            status,
   input  logic [TAP_IDX_W-1:0]       req_tap_index,
   input  logic signed [SAMPLE_W-1:0] req_tap_value,
   input  logic signed [SAMPLE_W-1:0] req_sample_i,
   input  logic signed [SAMPLE_W-1:0] req_sample_q,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [GAIN_W-1:0]          csr_output_gain,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_out_i,
   output logic signed [SAMPLE_W-1:0] rsp_out_q,
   output logic                       rsp_clipped
);

   localparam int ADDR_W  = $clog2(TAP_COUNT);
   localparam int ACC_W   = PROD_W + $clog2(TAP_COUNT);
   localparam int LO_W    = ACC_W / 2;
   localparam int HI_W    = ACC_W - LO_W;
   localparam int PLO_W   = LO_W + GAIN_W;
   localparam int PHI_W   = HI_W + GAIN_W + 1;
   localparam int SCALE_W = ACC_W + GAIN_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAP_COUNT - 1);

   // memories
   logic signed [SAMPLE_W-1:0] tap_mem     [TAP_COUNT];
   logic signed [SAMPLE_W-1:0] delay_i_mem [TAP_COUNT];
   logic signed [SAMPLE_W-1:0] delay_q_mem [TAP_COUNT];

   logic [ADDR_W-1:0]          cnt_ff, cnt_in;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic [ADDR_W-1:0]          rp_ff, rp_in;
   logic                       v1_ff, v2_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_W-1:0] tap_rd_ff, di_rd_ff, dq_rd_ff;
   logic signed [PROD_W-1:0]   prod_i_ff, prod_q_ff;
   logic signed [ACC_W-1:0]    acc_i_ff, acc_i_in, acc_q_ff, acc_q_in;
   logic [PLO_W-1:0]           plo_i_ff, plo_q_ff;
   logic signed [PHI_W-1:0]    phi_i_ff, phi_q_ff;
   logic signed [SCALE_W-1:0]  scl_i_ff, scl_q_ff;
   logic [SAMPLE_W:0]          sat_i, sat_q;
   logic signed [SAMPLE_W-1:0] out_i_ff, out_q_ff;
   logic                       clip_ff;

   logic                       tap_in_range;
   logic [ADDR_W-1:0]          dl_waddr;
   logic signed [SAMPLE_W-1:0] dl_wdata_i, dl_wdata_q;

   // {clip, value}: keep bits [45:30] unless the upper bits disagree
   function automatic logic [SAMPLE_W:0] sat16(input logic signed [SCALE_W-1:0] v);
      logic [SCALE_W-FRAC_SHIFT-SAMPLE_W:0] upper;
      logic [SAMPLE_W:0]                    res;
      upper = v[SCALE_W-1:FRAC_SHIFT+SAMPLE_W-1];
      if ((&upper) || !(|upper)) begin
         res = {1'b0, v[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT]};
      end else begin
         res = {1'b1, v[SCALE_W-1] ? SAT_MIN : SAT_MAX};
      end
      return res;
   endfunction

   assign tap_in_range = 32'(req_tap_index) < 32'(TAP_COUNT);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_step || cmd.mac_issue) begin
         cnt_in = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
      end else if (cmd.start_sample) begin
         cnt_in = '0;
      end
   end

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (cmd.start_sample) begin
         wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
         rp_in = wp_in;   // oldest entry sits right after the newest
      end else if (cmd.mac_issue) begin
         rp_in = (rp_ff == LAST_ADDR) ? '0 : rp_ff + 1'b1;
      end
   end

   always_comb begin
      acc_i_in = acc_i_ff;
      acc_q_in = acc_q_ff;
      if (cmd.start_sample) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (v2_ff) begin
         acc_i_in = acc_i_ff + ACC_W'(prod_i_ff);
         acc_q_in = acc_q_ff + ACC_W'(prod_q_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         wp_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         v1_ff        <= cmd.mac_issue;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) gain_ff <= csr_output_gain;
      end
   end

   // tap table: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.load_tap && tap_in_range) begin
         tap_mem[ADDR_W'(req_tap_index)] <= req_tap_value;
      end
      if (cmd.mac_issue) tap_rd_ff <= tap_mem[cnt_ff];
   end

   // delay lines as circular buffers, zeroed by the clearing pass
   assign dl_waddr   = cmd.clear_step ? cnt_ff : wp_ff;
   assign dl_wdata_i = cmd.clear_step ? '0 : req_sample_i;
   assign dl_wdata_q = cmd.clear_step ? '0 : req_sample_q;

   always_ff @(posedge clock) begin
      if (cmd.clear_step || cmd.start_sample) begin
         delay_i_mem[dl_waddr] <= dl_wdata_i;
         delay_q_mem[dl_waddr] <= dl_wdata_q;
      end
      if (cmd.mac_issue) begin
         di_rd_ff <= delay_i_mem[rp_ff];
         dq_rd_ff <= delay_q_mem[rp_ff];
      end
   end

   // arithmetic pipeline
   always_ff @(posedge clock) begin
      rp_ff     <= rp_in;
      prod_i_ff <= tap_rd_ff * di_rd_ff;
      prod_q_ff <= tap_rd_ff * dq_rd_ff;
      acc_i_ff  <= acc_i_in;
      acc_q_ff  <= acc_q_in;
      if (cmd.gain_lo) begin
         plo_i_ff <= acc_i_ff[LO_W-1:0] * gain_ff;
         plo_q_ff <= acc_q_ff[LO_W-1:0] * gain_ff;
      end
      if (cmd.gain_hi) begin
         phi_i_ff <= $signed(acc_i_ff[ACC_W-1:LO_W]) * $signed({1'b0, gain_ff});
         phi_q_ff <= $signed(acc_q_ff[ACC_W-1:LO_W]) * $signed({1'b0, gain_ff});
      end
      if (cmd.sum) begin
         scl_i_ff <= (SCALE_W'(phi_i_ff) <<< LO_W) + $signed(SCALE_W'(plo_i_ff));
         scl_q_ff <= (SCALE_W'(phi_q_ff) <<< LO_W) + $signed(SCALE_W'(plo_q_ff));
      end
      if (cmd.out_load) begin
         out_i_ff <= sat_i[SAMPLE_W-1:0];
         out_q_ff <= sat_q[SAMPLE_W-1:0];
         clip_ff  <= sat_i[SAMPLE_W] | sat_q[SAMPLE_W];
      end
   end

   assign sat_i = sat16(scl_i_ff);
   assign sat_q = sat16(scl_q_ff);

   assign status.cnt_last  = cnt_ff == LAST_ADDR;
   assign status.pipe_busy = v1_ff | v2_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_i   = out_i_ff;
   assign rsp_out_q   = out_q_ff;
   assign rsp_clipped = clip_ff;

endmodule

FILE: hw/rtl/cfps_checker.sv
// ----------------------------------------------------------------------------
// cfps_checker
// Port-level checks on the pulse shaper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "complex_fir_pulse_shaper_top_macros.svh"

module cfps_checker
   import cfps_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_op,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SAMPLE_W-1:0] rsp_out_i,
   input logic [SAMPLE_W-1:0] rsp_out_q,
   input logic                rsp_clipped
);

   // a stalled response holds
   `CFPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_i) && $stable(rsp_out_q) && $stable(rsp_clipped))

   // a sample request occupies the MAC
   `CFPS_ASSERT_NEXT(a_sample_busy, clock, reset, req_valid && !req_stall && req_op == OP_SAMPLE, req_stall)

   // a tap load leaves the block ready
   `CFPS_ASSERT_NEXT(a_load_ready, clock, reset, req_valid && !req_stall && req_op == OP_LOAD, !req_stall)

   // a new response only follows a busy period
   `CFPS_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind complex_fir_pulse_shaper_top cfps_checker u_cfps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_i   (rsp_out_i),
   .rsp_out_q   (rsp_out_q),
   .rsp_clipped (rsp_clipped)
);

FILE: tb/complex_fir_pulse_shaper_top_tb.sv
// ----------------------------------------------------------------------------
// complex_fir_pulse_shaper_top_tb
// Self-checking bench for the complex FIR pulse shaper. A queue of requests
// (tap loads and I/Q samples) feeds a falling-edge driver, and a rising-edge
// monitor keeps its own tap table, delay lines and gain. From these it works
// out each filtered, scaled and saturated output and checks them in order.
// Phases sweep the gain, the tap sets and the idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_fir_pulse_shaper_top_tb;
   import cfps_pkg::*;

   localparam int TB_TAPS        = TAP_COUNT_DEF;
   // long enough for a whole sample to pass, with some margin on top
   localparam int SETTLE_CYCLES  = TB_TAPS + 24;
   localparam int WATCHDOG_LIMIT = 8 * SETTLE_CYCLES;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASE_COUNT    = 5;
   localparam int PHASE_REQS     = 60;
   localparam int TAP_REWRITES   = 24;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef enum int {
      TAPS_IMPULSE,
      TAPS_EXTREME,
      TAPS_SMALL,
      TAPS_FULL
   } tap_style_type;

   typedef struct packed {
      logic                       op;
      logic [TAP_IDX_W-1:0]       tap_index;
      logic signed [SAMPLE_W-1:0] tap_value;
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
   } shaper_request_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_i;
      logic signed [SAMPLE_W-1:0] out_q;
      logic                       clipped;
   } shaper_result_type;

   // ---------------------------------------------------------------------------
   // DUT signals, the driven ones all known from time zero
   // ---------------------------------------------------------------------------
   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_stall;
   logic                       req_op          = OP_LOAD;
   logic [TAP_IDX_W-1:0]       req_tap_index   = '0;
   logic signed [SAMPLE_W-1:0] req_tap_value   = '0;
   logic signed [SAMPLE_W-1:0] req_sample_i    = '0;
   logic signed [SAMPLE_W-1:0] req_sample_q    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall       = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_i;
   logic signed [SAMPLE_W-1:0] rsp_out_q;
   logic                       rsp_clipped;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [GAIN_W-1:0]          csr_output_gain = '0;

   // ---------------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------------
   shaper_request_type         pending_reqs[$];    // waiting for the driver
   shaper_result_type          expected_outputs[$];
   int                         queued_reqs     = 0;
   int                         accepted_reqs   = 0;
   int                         error_count     = 0;
   int                         quiet_cycles    = 0;
   logic                       req_fired       = 1'b0;
   idle_mode_type              idle_mode       = IDLE_NONE;

   // shadow copy of the filter state
   logic signed [SAMPLE_W-1:0] tap_coeffs[TB_TAPS];
   logic signed [SAMPLE_W-1:0] hist_i[TB_TAPS];
   logic signed [SAMPLE_W-1:0] hist_q[TB_TAPS];
   logic [GAIN_W-1:0]          active_gain     = GAIN_RESET;

   complex_fir_pulse_shaper_top #(
      .TAP_COUNT(TB_TAPS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_tap_index   (req_tap_index),
      .req_tap_value   (req_tap_value),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_i       (rsp_out_i),
      .rsp_out_q       (rsp_out_q),
      .rsp_clipped     (rsp_clipped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_output_gain (csr_output_gain)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   // clip flag in the top bit, saturated value below
   function automatic logic [SAMPLE_W:0] saturate_component(input longint v);
      if (v > 32767)
         return {1'b1, SAT_MAX};
      if (v < -32768)
         return {1'b1, SAT_MIN};
      return {1'b0, v[SAMPLE_W-1:0]};
   endfunction

   // Apply one accepted request to the shadow state; a sample also yields
   // the output it should produce.
   function automatic void shape_request(input shaper_request_type r);
      longint            acc_i = 0;
      longint            acc_q = 0;
      logic [SAMPLE_W:0] sat_i;
      logic [SAMPLE_W:0] sat_q;
      shaper_result_type res;
      if (r.op == OP_LOAD) begin
         // indexes beyond the table are dropped by the block
         if (r.tap_index < TB_TAPS)
            tap_coeffs[r.tap_index] = r.tap_value;
         return;
      end
      // entry 0 is the newest sample
      for (int k = TB_TAPS - 1; k > 0; k--) begin
         hist_i[k] = hist_i[k-1];
         hist_q[k] = hist_q[k-1];
      end
      hist_i[0] = r.sample_i;
      hist_q[0] = r.sample_q;
      // tap 0 meets the oldest sample; Q1.15 x Q1.15 sums exact in 64 bits
      for (int j = 0; j < TB_TAPS; j++) begin
         acc_i += longint'(tap_coeffs[j]) * longint'(hist_i[TB_TAPS-1-j]);
         acc_q += longint'(tap_coeffs[j]) * longint'(hist_q[TB_TAPS-1-j]);
      end
      // arithmetic shift floors towards minus infinity
      sat_i = saturate_component((acc_i * longint'(active_gain)) >>> FRAC_SHIFT);
      sat_q = saturate_component((acc_q * longint'(active_gain)) >>> FRAC_SHIFT);
      res.out_i   = sat_i[SAMPLE_W-1:0];
      res.out_q   = sat_q[SAMPLE_W-1:0];
      res.clipped = sat_i[SAMPLE_W] | sat_q[SAMPLE_W];
      expected_outputs.push_back(res);
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   // all fields random, so the ignored ones wiggle too
   function automatic shaper_request_type random_request();
      shaper_request_type r;
      r.op        = 1'($urandom_range(0, 1));
      r.tap_index = TAP_IDX_W'($urandom_range(0, 511));
      r.tap_value = SAMPLE_W'($urandom);
      r.sample_i  = SAMPLE_W'($urandom);
      r.sample_q  = SAMPLE_W'($urandom);
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 19))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic push_request(input shaper_request_type r);
      pending_reqs.push_back(r);
      queued_reqs++;
   endtask

   task automatic push_load(input int idx, input logic signed [SAMPLE_W-1:0] value);
      shaper_request_type r;
      r           = random_request();
      r.op        = OP_LOAD;
      r.tap_index = TAP_IDX_W'(idx);
      r.tap_value = value;
      push_request(r);
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] si,
                              input logic signed [SAMPLE_W-1:0] sq);
      shaper_request_type r;
      r          = random_request();
      r.op       = OP_SAMPLE;
      r.sample_i = si;
      r.sample_q = sq;
      push_request(r);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] tap_coeff_for(input tap_style_type style,
                                                                input int j);
      logic signed [SAMPLE_W-1:0] v;
      case (style)
         TAPS_IMPULSE:
            // only the two taps nearest the newest sample are live
            v = (j == TB_TAPS - 1) ? 16'sh7FFF :
                (j == TB_TAPS - 2) ? 16'sh8000 : 16'sh0000;
         TAPS_EXTREME:
            v = (j == TB_TAPS - 1) ? 16'sh8000 : 16'sh7FFF;
         TAPS_SMALL:
            v = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
         default:
            v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   // load every tap, so no sample ever reads an unwritten one
   task automatic push_tap_set(input tap_style_type style);
      for (int j = 0; j < TB_TAPS; j++)
         push_load(j, tap_coeff_for(style, j));
   endtask

   // rewrite a few randomly picked taps; the rest keep their values
   task automatic push_tap_rewrites(input tap_style_type style, input int count);
      int j;
      for (int n = 0; n < count; n++) begin
         j = int'($urandom_range(0, TB_TAPS - 1));
         push_load(j, tap_coeff_for(style, j));
      end
   endtask

   // block idle: every request taken, every output seen, pipeline drained
   task automatic wait_idle();
      do
         @(negedge clock);
      while (accepted_reqs != queued_reqs || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] gain);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_output_gain <= gain;
      do
         @(posedge clock);
      while (!csr_ready);
      active_gain = gain;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Driver: requests from the pending queue, changes on the falling edge.
   // A request stays put until the monitor saw it accepted.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      shaper_request_type r;
      int                 send_idle;
      int                 recv_stall;
      send_idle  = (idle_mode == IDLE_SENDER)   ? 72 :
                   (idle_mode == IDLE_BOTH)     ? 34 : 0;
      recv_stall = (idle_mode == IDLE_RECEIVER) ? 72 :
                   (idle_mode == IDLE_BOTH)     ? 34 : 0;
      if (req_valid && !req_fired) begin
         // stalled: hold the payload
      end else if (!reset && pending_reqs.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle) begin
         r              = pending_reqs.pop_front();
         req_op        <= r.op;
         req_tap_index <= r.tap_index;
         req_tap_value <= r.tap_value;
         req_sample_i  <= r.sample_i;
         req_sample_q  <= r.sample_q;
         req_valid     <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall);
   end

   // ---------------------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each accepted output
   // against the oldest expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      shaper_request_type r;
      shaper_result_type  want;
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         r.op        = req_op;
         r.tap_index = req_tap_index;
         r.tap_value = req_tap_value;
         r.sample_i  = req_sample_i;
         r.sample_q  = req_sample_q;
         shape_request(r);
         accepted_reqs++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            if (error_count < 10)
               $display("[%0t] unexpected output: i=%0d q=%0d clipped=%0b",
                        $realtime, rsp_out_i, rsp_out_q, rsp_clipped);
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_out_i !== want.out_i || rsp_out_q !== want.out_q ||
                rsp_clipped !== want.clipped) begin
               if (error_count < 10)
                  $display("[%0t] mismatch: exp i=%0d q=%0d clip=%0b, got i=%0d q=%0d clip=%0b",
                           $realtime, want.out_i, want.out_q, want.clipped,
                           rsp_out_i, rsp_out_q, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long without any handshake on any channel
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("complex_fir_pulse_shaper_top_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      idle_mode_type     phase_mode[PHASE_COUNT] =
         '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_RECEIVER};
      tap_style_type     phase_taps[PHASE_COUNT] =
         '{TAPS_FULL, TAPS_SMALL, TAPS_EXTREME, TAPS_FULL, TAPS_SMALL};
      logic [GAIN_W-1:0] phase_gain[PHASE_COUNT];

      phase_gain = '{15'd32767, 15'd0, 15'd1, 15'd1500, 15'd1500};
      phase_gain[3] = GAIN_W'($urandom_range(2, 32766));

      foreach (hist_i[k]) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed: reset gain, two-tap impulse so outputs show at once ---
      idle_mode = IDLE_NONE;
      push_tap_set(TAPS_IMPULSE);
      // loads beyond the table must leave it alone
      push_load(TB_TAPS, 16'sh7FFF);
      push_load(511, 16'sh8000);
      push_sample(16'sh7FFF, 16'sh8000);
      push_sample(16'sh8000, 16'sh7FFF);
      push_sample(16'sh0000, 16'sh0000);
      push_sample(-16'sd1, 16'sd1);
      push_sample(16'sd1, -16'sd1);
      push_sample(16'sh7FFF, 16'sh7FFF);
      push_sample(16'sh8000, 16'sh8000);

      // --- directed: full gain on the impulse taps, both rails clip ---
      wait_idle();
      write_gain(15'd32767);
      push_sample(16'sh7FFF, 16'sh8000);
      push_sample(16'sh7FFF, 16'sh8000);
      push_sample(16'sh8000, 16'sh7FFF);
      push_sample(16'sh0000, 16'sh0000);
      push_sample(16'sh8000, 16'sh7FFF);
      push_sample(16'sh0000, 16'sh0000);

      // --- random phases: fresh gain, some taps rewritten, then samples ---
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         write_gain(phase_gain[p]);
         idle_mode = phase_mode[p];
         push_tap_rewrites(phase_taps[p], TAP_REWRITES);
         for (int n = 0; n < PHASE_REQS; n++) begin
            if ($urandom_range(0, 99) < 8)
               // odd tap rewrite mid-stream, in range or not
               push_load(int'($urandom_range(0, 511)), SAMPLE_W'($urandom));
            else
               push_sample(random_sample(), random_sample());
         end
      end

      // a short run of trailing zeros before the end
      for (int n = 0; n < 4; n++)
         push_sample(16'sh0000, 16'sh0000);

      wait_idle();
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("complex_fir_pulse_shaper_top_tb passed");
      end else begin
         $display("complex_fir_pulse_shaper_top_tb failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cfps_pkg.sv
hw/rtl/cfps_ctrl.sv
hw/rtl/cfps_datapath.sv
hw/rtl/complex_fir_pulse_shaper_top.sv
hw/rtl/cfps_checker.sv
tb/complex_fir_pulse_shaper_top_tb.sv
